// File: hw/rtl/ucb_pkg.sv
package ucb_pkg;

  localparam int unsigned MAX_ACTIONS_DEF = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 24;

  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned MANT_W   = 31;
  localparam int unsigned LN_W     = 22;
  localparam int unsigned RAD_W    = LN_W + FRAC_W;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned BONUS_W  = ROOT_W + FRAC_W;
  localparam int unsigned CNT_W    = 5;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [31:0] EXPL_RESET = 32'h0001_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  localparam logic [CNT_W-1:0] SQUARE_LAST = CNT_W'(FRAC_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(LN_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(ROOT_W - 1);

  localparam logic REG_EXPL   = 1'b0;
  localparam logic REG_GREEDY = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NORM,
    OP_MANT,
    OP_SQUARE,
    OP_LNMUL,
    OP_DIV,
    OP_ROOTLD,
    OP_SQRT,
    OP_BONUS,
    OP_SCORE,
    OP_UPDATE
  } ucb_op_e;

  typedef struct packed {
    ucb_op_e op;
  } ucb_cmd_t;

  typedef struct packed {
    logic ucb_needed;
    logic norm_done;
    logic last;
    logic out_free;
  } ucb_status_t;

endpackage

// File: hw/rtl/ucb_if.sv
interface ucb_in_if #(
  parameter int unsigned COUNT_WIDTH = ucb_pkg::COUNT_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           child_value;
  logic [COUNT_WIDTH-1:0]       child_visits;
  logic [COUNT_WIDTH-1:0]       parent_visits;
  logic                         last_child;

  modport source (output valid, child_value, child_visits, parent_visits, last_child,
                  input ready);
  modport sink (input valid, child_value, child_visits, parent_visits, last_child,
                output ready);
endinterface

interface ucb_out_if #(
  parameter int unsigned MAX_ACTIONS = ucb_pkg::MAX_ACTIONS_DEF
) ();
  logic                               valid;
  logic                               ready;
  logic [$clog2(MAX_ACTIONS)-1:0]     chosen_action;
  logic signed [31:0]                 chosen_score;
  logic                               chose_unvisited;

  modport source (output valid, chosen_action, chosen_score, chose_unvisited, input ready);
  modport sink (input valid, chosen_action, chosen_score, chose_unvisited, output ready);
endinterface

// File: hw/rtl/ucb_cfg_regs.sv
module ucb_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] expl_const_o,
  output logic        greedy_mode_o
);

  logic [31:0] expl_q, expl_d;
  logic        greedy_q, greedy_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    expl_d   = expl_q;
    greedy_d = greedy_q;
    if (wr_en) begin
      unique case (paddr[2])
        ucb_pkg::REG_EXPL:   expl_d   = pwdata;
        ucb_pkg::REG_GREEDY: greedy_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ucb_pkg::REG_EXPL:   prdata = expl_q;
      ucb_pkg::REG_GREEDY: prdata = {31'b0, greedy_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expl_q   <= ucb_pkg::EXPL_RESET;
      greedy_q <= 1'b0;
    end else begin
      expl_q   <= expl_d;
      greedy_q <= greedy_d;
    end
  end

  assign expl_const_o  = expl_q;
  assign greedy_mode_o = greedy_q;

endmodule

// File: hw/rtl/ucb_ctrl.sv
module ucb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ucb_pkg::ucb_status_t status_i,
  output ucb_pkg::ucb_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_NORM   = 11'b000_0000_0010,
    S_MANT   = 11'b000_0000_0100,
    S_SQUARE = 11'b000_0000_1000,
    S_LNMUL  = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_ROOTLD = 11'b000_0100_0000,
    S_SQRT   = 11'b000_1000_0000,
    S_BONUS  = 11'b001_0000_0000,
    S_SCORE  = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [ucb_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = ucb_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ucb_pkg::OP_LOAD;
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        if (!status_i.ucb_needed) begin
          state_d = S_FINISH;
        end else if (status_i.norm_done) begin
          state_d = S_MANT;
        end else begin
          cmd_o.op = ucb_pkg::OP_NORM;
        end
      end
      S_MANT: begin
        cmd_o.op = ucb_pkg::OP_MANT;
        cnt_d    = '0;
        state_d  = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.op = ucb_pkg::OP_SQUARE;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ucb_pkg::SQUARE_LAST) state_d = S_LNMUL;
      end
      S_LNMUL: begin
        cmd_o.op = ucb_pkg::OP_LNMUL;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = ucb_pkg::OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ucb_pkg::DIV_LAST) state_d = S_ROOTLD;
      end
      S_ROOTLD: begin
        cmd_o.op = ucb_pkg::OP_ROOTLD;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = ucb_pkg::OP_SQRT;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ucb_pkg::SQRT_LAST) state_d = S_BONUS;
      end
      S_BONUS: begin
        cmd_o.op = ucb_pkg::OP_BONUS;
        state_d  = S_SCORE;
      end
      S_SCORE: begin
        cmd_o.op = ucb_pkg::OP_SCORE;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        // for a last child, hold while the previous result has not been taken
        if (!status_i.last || status_i.out_free) begin
          cmd_o.op = ucb_pkg::OP_UPDATE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/ucb_datapath.sv
module ucb_datapath #(
  parameter int unsigned MAX_ACTIONS = ucb_pkg::MAX_ACTIONS_DEF,
  parameter int unsigned COUNT_WIDTH = ucb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ucb_pkg::ucb_cmd_t               cmd_i,
  output ucb_pkg::ucb_status_t            status_o,
  input  logic signed [31:0]              child_value_i,
  input  logic [COUNT_WIDTH-1:0]          child_visits_i,
  input  logic [COUNT_WIDTH-1:0]          parent_visits_i,
  input  logic                            last_child_i,
  input  logic [31:0]                     expl_const_i,
  input  logic                            greedy_mode_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [$clog2(MAX_ACTIONS)-1:0]  chosen_action_o,
  output logic signed [31:0]              chosen_score_o,
  output logic                            chose_unvisited_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned AW     = $clog2(MAX_ACTIONS);
  localparam int unsigned IW     = $clog2(MAX_ACTIONS + 1);
  localparam int unsigned EW     = $clog2(COUNT_WIDTH + 1);
  localparam int unsigned FW     = ucb_pkg::FRAC_W;
  localparam int unsigned MW     = ucb_pkg::MANT_W;
  localparam int unsigned LW     = ucb_pkg::LN_W;
  localparam int unsigned VW     = ucb_pkg::RAD_W;
  localparam int unsigned RW     = ucb_pkg::ROOT_W;
  localparam int unsigned BW     = ucb_pkg::BONUS_W;
  localparam int unsigned SW     = ucb_pkg::SCORE_W;

  // item registers
  logic signed [SW-1:0] value_q;
  logic [CW-1:0]        visits_q;
  logic                 last_q;
  // log unit
  logic [CW:0]          w_q;
  logic [EW-1:0]        e_q;
  logic [MW-1:0]        m_q;
  logic [FW-1:0]        frac_q;
  // divider
  logic [LW-1:0]        quo_q;
  logic [CW-1:0]        rem_q;
  // square root
  logic [VW-1:0]        rad_q;
  logic [RW:0]          srem_q;
  logic [RW-1:0]        root_q;
  // score
  logic [BW-1:0]        bonus_q;
  logic signed [SW-1:0] score_q;
  // selection state
  logic [IW-1:0]        idx_q;
  logic signed [SW-1:0] best_q;
  logic [AW-1:0]        best_idx_q;
  logic                 unv_q;
  // result register
  logic                 out_valid_q;
  logic [AW-1:0]        out_idx_q;
  logic signed [SW-1:0] out_score_q;
  logic                 out_unv_q;

  logic                 active;
  logic                 first;
  logic [CW+32:0]       wext;
  logic [2*MW-1:0]      sq;
  logic [MW:0]          sq_t;
  logic [VW-1:0]        lnp;
  logic [CW:0]          div_sh;
  logic [RW+2:0]        sr_sh;
  logic [RW+2:0]        sr_trial;
  logic [SW+RW-1:0]     bprod;
  logic signed [BW+1:0] sum;
  logic signed [SW-1:0] sum_sat;
  logic signed [SW-1:0] nb_score;
  logic [AW-1:0]        nb_idx;
  logic                 nb_unv;
  logic                 out_free;

  assign active   = (idx_q < IW'(MAX_ACTIONS)) && !unv_q;
  assign first    = (idx_q == '0);
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.ucb_needed = active && !greedy_mode_i && (visits_q != '0);
  assign status_o.norm_done  = w_q[CW];
  assign status_o.last       = last_q;
  assign status_o.out_free   = out_free;

  assign wext     = {w_q, 32'b0};
  assign sq       = (2*MW)'(m_q) * (2*MW)'(m_q);
  assign sq_t     = sq[2*MW-1:MW-1];
  assign lnp      = VW'({e_q, frac_q}) * VW'(ucb_pkg::LN2_Q16);
  assign div_sh   = {rem_q, quo_q[LW-1]};
  assign sr_sh    = {srem_q, rad_q[VW-1:VW-2]};
  assign sr_trial = {1'b0, root_q, 2'b01};
  assign bprod    = (SW+RW)'(expl_const_i) * (SW+RW)'(root_q);
  assign sum      = (BW+2)'(value_q) + $signed({2'b00, bonus_q});

  always_comb begin
    if (sum > (BW+2)'(ucb_pkg::SCORE_MAX))      sum_sat = ucb_pkg::SCORE_MAX;
    else if (sum < (BW+2)'(ucb_pkg::SCORE_MIN)) sum_sat = ucb_pkg::SCORE_MIN;
    else                                         sum_sat = sum[SW-1:0];
  end

  // next selection for the child being retired
  always_comb begin
    nb_score = best_q;
    nb_idx   = best_idx_q;
    nb_unv   = unv_q;
    if (active) begin
      if (greedy_mode_i) begin
        if (first || value_q > best_q) begin
          nb_score = value_q;
          nb_idx   = idx_q[AW-1:0];
        end
      end else if (visits_q == '0) begin
        nb_unv   = 1'b1;
        nb_score = ucb_pkg::SCORE_MAX;
        nb_idx   = idx_q[AW-1:0];
      end else if (first || score_q > best_q) begin
        nb_score = score_q;
        nb_idx   = idx_q[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ucb_pkg::OP_LOAD: begin
        value_q  <= child_value_i;
        visits_q <= child_visits_i;
        last_q   <= last_child_i;
        w_q      <= {1'b0, parent_visits_i} + 1'b1;
        e_q      <= EW'(CW);
      end
      ucb_pkg::OP_NORM: begin
        w_q <= {w_q[CW-1:0], 1'b0};
        e_q <= e_q - 1'b1;
      end
      ucb_pkg::OP_MANT: begin
        m_q    <= wext[CW+32 -: MW];
        frac_q <= '0;
      end
      ucb_pkg::OP_SQUARE: begin
        frac_q <= {frac_q[FW-2:0], sq_t[MW]};
        m_q    <= sq_t[MW] ? sq_t[MW:1] : sq_t[MW-1:0];
      end
      ucb_pkg::OP_LNMUL: begin
        quo_q <= lnp[LW+FW-1:FW];
        rem_q <= '0;
      end
      ucb_pkg::OP_DIV: begin
        if (div_sh >= {1'b0, visits_q}) begin
          rem_q <= CW'(div_sh - {1'b0, visits_q});
          quo_q <= {quo_q[LW-2:0], 1'b1};
        end else begin
          rem_q <= div_sh[CW-1:0];
          quo_q <= {quo_q[LW-2:0], 1'b0};
        end
      end
      ucb_pkg::OP_ROOTLD: begin
        rad_q  <= {quo_q, {FW{1'b0}}};
        srem_q <= '0;
        root_q <= '0;
      end
      ucb_pkg::OP_SQRT: begin
        rad_q <= {rad_q[VW-3:0], 2'b00};
        if (sr_sh >= sr_trial) begin
          srem_q <= (RW+1)'(sr_sh - sr_trial);
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          srem_q <= sr_sh[RW:0];
          root_q <= {root_q[RW-2:0], 1'b0};
        end
      end
      ucb_pkg::OP_BONUS: bonus_q <= bprod[SW+RW-1:FW];
      ucb_pkg::OP_SCORE: score_q <= sum_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      best_q      <= ucb_pkg::SCORE_MIN;
      best_idx_q  <= '0;
      unv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_score_q <= '0;
      out_unv_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == ucb_pkg::OP_UPDATE) begin
        if (last_q) begin
          out_valid_q <= 1'b1;
          out_idx_q   <= nb_idx;
          out_score_q <= nb_score;
          out_unv_q   <= nb_unv;
          idx_q       <= '0;
          best_q      <= ucb_pkg::SCORE_MIN;
          best_idx_q  <= '0;
          unv_q       <= 1'b0;
        end else begin
          best_q     <= nb_score;
          best_idx_q <= nb_idx;
          unv_q      <= nb_unv;
          if (idx_q < IW'(MAX_ACTIONS)) idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chosen_action_o   = out_idx_q;
  assign chosen_score_o    = out_score_q;
  assign chose_unvisited_o = out_unv_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(MAX_ACTIONS))
    else $error("child index beyond saturation");

  a_unv_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unv_q |-> best_q == ucb_pkg::SCORE_MAX)
    else $error("unvisited child held without top score");

  a_out_unv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_unv_q) |-> out_score_q == ucb_pkg::SCORE_MAX)
    else $error("unvisited result without saturated score");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ucb_pkg::OP_UPDATE && last_q) |-> out_free)
    else $error("result register overwritten before transfer");

endmodule

// File: hw/rtl/ucb1_child_selector_unit.sv
// One child per transfer. Greedy, unvisited or ignored children go from
// transfer through NORM and FINISH back to ready; a UCB-scored child runs
// through the log unit (bit-serial normalise, 16 squarings), a 22-step
// divider and a 19-step square root. One child is in work at a time; the
// result register holds a finished result while the next child runs. Reset
// clears the selection state, the result register and loads the register
// defaults.
module ucb1_child_selector_unit #(
  parameter int unsigned MAX_ACTIONS = ucb_pkg::MAX_ACTIONS_DEF,
  parameter int unsigned COUNT_WIDTH = ucb_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucb_in_if.sink      in_i,
  ucb_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ucb_pkg::ucb_cmd_t    cmd;
  ucb_pkg::ucb_status_t status;
  logic [31:0]          expl_const;
  logic                 greedy_mode;

  ucb_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .expl_const_o  (expl_const),
    .greedy_mode_o (greedy_mode)
  );

  ucb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ucb_datapath #(
    .MAX_ACTIONS (MAX_ACTIONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .child_value_i     (in_i.child_value),
    .child_visits_i    (in_i.child_visits),
    .parent_visits_i   (in_i.parent_visits),
    .last_child_i      (in_i.last_child),
    .expl_const_i      (expl_const),
    .greedy_mode_i     (greedy_mode),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .chosen_action_o   (res_o.chosen_action),
    .chosen_score_o    (res_o.chosen_score),
    .chose_unvisited_o (res_o.chose_unvisited)
  );

endmodule
